[hw/rtl/cau_pkg.sv]
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

  localparam int CMD_BITS = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4,
    CMD_NE  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  // Control bits that ride along the divider chain.
  typedef struct packed {
    logic    cmp;
    status_t status;
    logic    is_div;
  } ctl_t;

endpackage

[hw/rtl/cau_in_if.sv]
// Operand channel: command plus two complex operands.
interface cau_in_if
  import cau_pkg::*;
#(
  parameter int WORD_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [CMD_BITS-1:0]         command;
  logic signed [WORD_BITS-1:0] a_re;
  logic signed [WORD_BITS-1:0] a_im;
  logic signed [WORD_BITS-1:0] b_re;
  logic signed [WORD_BITS-1:0] b_im;

  modport source(output valid, command, a_re, a_im, b_re, b_im, input ready);
  modport sink(input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

[hw/rtl/cau_out_if.sv]
// Result channel: complex result, compare flag and status.
interface cau_out_if #(
  parameter int WORD_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_re;
  logic signed [WORD_BITS-1:0] res_im;
  logic                        compare_true;
  logic [1:0]                  status;

  modport source(output valid, res_re, res_im, compare_true, status, input ready);
  modport sink(input valid, res_re, res_im, compare_true, status, output ready);
endinterface

[hw/rtl/complex_arithmetic_unit.sv]
// From accept to result: front-end stages, divider stages, output register (Q8.8 by default).
// Throughput: one transaction per cycle; the whole pipe advances together and
//   freezes only while the output register holds a result nobody takes.
// The long pole is the divider: one restoring quotient bit per stage.
// Reset: synchronous, active high; clears all valid bits, no pending results.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic     clk,
  input  logic     rst,
  cau_in_if.sink   operands,
  cau_out_if.source results
);
  localparam int W  = WORD_BITS;
  localparam int MW = 2 * WORD_BITS;
  localparam int QW = MW + FRAC_BITS;
  localparam logic [QW-1:0] HALF   = QW'(1) << (W - 1);
  localparam logic [W-1:0]  MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINNEG = {1'b1, {(W-1){1'b0}}};

  // Global advance: the pipe moves when the output slot is free or drains.
  logic en;
  assign en             = !results.valid || results.ready;
  assign operands.ready = en;

  logic          f_valid;
  logic [MW-1:0] f_nre, f_nim, f_den;
  logic          f_nre_neg, f_nim_neg;
  logic [W-1:0]  f_fre, f_fim;
  ctl_t          f_ctl;

  cau_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (operands.valid),
    .command    (operands.command),
    .a_re       (operands.a_re),
    .a_im       (operands.a_im),
    .b_re       (operands.b_re),
    .b_im       (operands.b_im),
    .out_valid  (f_valid),
    .num_re_mag (f_nre),
    .num_re_neg (f_nre_neg),
    .num_im_mag (f_nim),
    .num_im_neg (f_nim_neg),
    .den        (f_den),
    .fast_re    (f_fre),
    .fast_im    (f_fim),
    .ctl        (f_ctl)
  );

  logic          d_valid;
  logic [QW-1:0] d_qre, d_qim;
  logic          d_qre_neg, d_qim_neg;
  logic [W-1:0]  d_fre, d_fim;
  ctl_t          d_ctl;

  cau_divider #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (f_valid),
    .num_re_mag (f_nre),
    .num_re_neg (f_nre_neg),
    .num_im_mag (f_nim),
    .num_im_neg (f_nim_neg),
    .den        (f_den),
    .fast_re_in (f_fre),
    .fast_im_in (f_fim),
    .ctl_in     (f_ctl),
    .out_valid  (d_valid),
    .q_re       (d_qre),
    .q_re_neg   (d_qre_neg),
    .q_im       (d_qim),
    .q_im_neg   (d_qim_neg),
    .fast_re    (d_fre),
    .fast_im    (d_fim),
    .ctl        (d_ctl)
  );

  // Quotient clamp: negative side reaches one step further than positive.
  function automatic logic [W:0] clamp_q(logic neg, logic [QW-1:0] q);
    logic [W:0] r;
    if (neg) begin
      if (q > HALF) r = {1'b1, MINNEG};
      else r = {1'b0, (~q[W-1:0]) + W'(1)};
    end else begin
      if (q > HALF - QW'(1)) r = {1'b1, MAXPOS};
      else r = {1'b0, q[W-1:0]};
    end
    return r;
  endfunction

  logic [W:0] cre, cim;
  always_comb begin
    cre = clamp_q(d_qre_neg, d_qre);
    cim = clamp_q(d_qim_neg, d_qim);
  end

  // Output register: divide results merge with the carried fast-path result.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en) begin
      results.valid <= d_valid;
    end
    if (en) begin
      results.compare_true <= d_ctl.cmp;
      if (d_ctl.is_div) begin
        results.res_re <= cre[W-1:0];
        results.res_im <= cim[W-1:0];
        results.status <= (cre[W] || cim[W]) ? ST_SAT : ST_OK;
      end else begin
        results.res_re <= d_fre;
        results.res_im <= d_fim;
        results.status <= d_ctl.status;
      end
    end
  end

  // A divide by zero always delivers zero parts.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == ST_DIV_ZERO
      |-> results.res_re == '0 && results.res_im == '0)
    else $error("divide by zero with nonzero result");

  // A true compare carries no arithmetic result.
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.compare_true
      |-> results.status == ST_OK && results.res_re == '0 && results.res_im == '0)
    else $error("compare result mixed with arithmetic");

  // Saturation leaves at least one part at a word limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == ST_SAT
      |-> results.res_re == MAXPOS || results.res_re == MINNEG
       || results.res_im == MAXPOS || results.res_im == MINNEG)
    else $error("saturation flagged without a clamped part");
endmodule

[hw/rtl/cau_front.sv]
// Front end: products, sums, fast-path results and divider operands (3 stages).
module cau_front
  import cau_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [CMD_BITS-1:0]           command,
  input  logic signed [WORD_BITS-1:0]   a_re,
  input  logic signed [WORD_BITS-1:0]   a_im,
  input  logic signed [WORD_BITS-1:0]   b_re,
  input  logic signed [WORD_BITS-1:0]   b_im,
  output logic                          out_valid,
  output logic [2*WORD_BITS-1:0]        num_re_mag,
  output logic                          num_re_neg,
  output logic [2*WORD_BITS-1:0]        num_im_mag,
  output logic                          num_im_neg,
  output logic [2*WORD_BITS-1:0]        den,
  output logic [WORD_BITS-1:0]          fast_re,
  output logic [WORD_BITS-1:0]          fast_im,
  output ctl_t                          ctl
);
  localparam int W  = WORD_BITS;
  localparam int MW = 2 * WORD_BITS;
  localparam logic [MW-1:0] HALF   = MW'(1) << (W - 1);
  localparam logic [W-1:0]  MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINNEG = {1'b1, {(W-1){1'b0}}};

  // {saturated, word} from sign and magnitude
  function automatic logic [W:0] clamp_sm(logic neg, logic [MW-1:0] mag);
    logic [W:0] r;
    if (neg) begin
      if (mag > HALF) r = {1'b1, MINNEG};
      else r = {1'b0, (~mag[W-1:0]) + W'(1)};
    end else begin
      if (mag > HALF - MW'(1)) r = {1'b1, MAXPOS};
      else r = {1'b0, mag[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [W:0] clamp_sum(logic signed [W:0] s);
    logic [W:0] r;
    if (s[W] != s[W-1]) r = {1'b1, s[W] ? MINNEG : MAXPOS};
    else r = {1'b0, s[W-1:0]};
    return r;
  endfunction

  // stage 1
  logic                   v1;
  logic [CMD_BITS-1:0]    cmd1;
  logic signed [MW-1:0]   prr, pii, pri, pir, pbr, pbi;
  logic signed [W:0]      sre1, sim1;
  logic                   eq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      cmd1 <= command;
      prr  <= a_re * b_re;
      pii  <= a_im * b_im;
      pri  <= a_re * b_im;
      pir  <= a_im * b_re;
      pbr  <= b_re * b_re;
      pbi  <= b_im * b_im;
      if (command == CMD_SUB) begin
        sre1 <= {a_re[W-1], a_re} - {b_re[W-1], b_re};
        sim1 <= {a_im[W-1], a_im} - {b_im[W-1], b_im};
      end else begin
        sre1 <= {a_re[W-1], a_re} + {b_re[W-1], b_re};
        sim1 <= {a_im[W-1], a_im} + {b_im[W-1], b_im};
      end
      eq1 <= (a_re == b_re) && (a_im == b_im);
    end
  end

  // stage 2
  logic                   v2;
  logic [CMD_BITS-1:0]    cmd2;
  logic signed [MW:0]     mre2, mim2, dre2, dim2;
  logic [MW-1:0]          den2;
  logic [W:0]             are2, aim2;
  logic                   eq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      cmd2 <= cmd1;
      mre2 <= {prr[MW-1], prr} - {pii[MW-1], pii};
      mim2 <= {pri[MW-1], pri} + {pir[MW-1], pir};
      dre2 <= {prr[MW-1], prr} + {pii[MW-1], pii};
      dim2 <= {pir[MW-1], pir} - {pri[MW-1], pri};
      den2 <= MW'($unsigned(pbr)) + MW'($unsigned(pbi));
      are2 <= clamp_sum(sre1);
      aim2 <= clamp_sum(sim1);
      eq2  <= eq1;
    end
  end

  // stage 3
  logic [MW:0]  mre_abs, mim_abs, dre_abs, dim_abs;
  logic [W:0]   mwre, mwim;
  logic [W-1:0] fast_re_next, fast_im_next;
  ctl_t         ctl_next;

  always_comb begin
    mre_abs = mre2[MW] ? -mre2 : mre2;
    mim_abs = mim2[MW] ? -mim2 : mim2;
    dre_abs = dre2[MW] ? -dre2 : dre2;
    dim_abs = dim2[MW] ? -dim2 : dim2;
    mwre = clamp_sm(mre2[MW], mre_abs[MW-1:0] >> FRAC_BITS);
    mwim = clamp_sm(mim2[MW], mim_abs[MW-1:0] >> FRAC_BITS);
    fast_re_next = '0;
    fast_im_next = '0;
    ctl_next     = '{cmp: 1'b0, status: ST_OK, is_div: 1'b0};
    case (cmd2)
      CMD_ADD, CMD_SUB: begin
        fast_re_next    = are2[W-1:0];
        fast_im_next    = aim2[W-1:0];
        ctl_next.status = (are2[W] || aim2[W]) ? ST_SAT : ST_OK;
      end
      CMD_MUL: begin
        fast_re_next    = mwre[W-1:0];
        fast_im_next    = mwim[W-1:0];
        ctl_next.status = (mwre[W] || mwim[W]) ? ST_SAT : ST_OK;
      end
      CMD_DIV: begin
        if (den2 == '0) ctl_next.status = ST_DIV_ZERO;
        else ctl_next.is_div = 1'b1;
      end
      CMD_EQ:  ctl_next.cmp = eq2;
      CMD_NE:  ctl_next.cmp = !eq2;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      num_re_mag <= dre_abs[MW-1:0];
      num_re_neg <= dre2[MW];
      num_im_mag <= dim_abs[MW-1:0];
      num_im_neg <= dim2[MW];
      den        <= den2;
      fast_re    <= fast_re_next;
      fast_im    <= fast_im_next;
      ctl        <= ctl_next;
    end
  end
endmodule

[hw/rtl/cau_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes.
module cau_divider
  import cau_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2*WORD_BITS-1:0]                num_re_mag,
  input  logic                                  num_re_neg,
  input  logic [2*WORD_BITS-1:0]                num_im_mag,
  input  logic                                  num_im_neg,
  input  logic [2*WORD_BITS-1:0]                den,
  input  logic [WORD_BITS-1:0]                  fast_re_in,
  input  logic [WORD_BITS-1:0]                  fast_im_in,
  input  ctl_t                                  ctl_in,
  output logic                                  out_valid,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]      q_re,
  output logic                                  q_re_neg,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]      q_im,
  output logic                                  q_im_neg,
  output logic [WORD_BITS-1:0]                  fast_re,
  output logic [WORD_BITS-1:0]                  fast_im,
  output ctl_t                                  ctl
);
  localparam int W  = WORD_BITS;
  localparam int MW = 2 * WORD_BITS;
  localparam int QW = MW + FRAC_BITS;

  logic          v     [QW+1];
  logic [MW-1:0] rre   [QW+1];
  logic [MW-1:0] rim   [QW+1];
  logic [QW-1:0] dqre  [QW+1];
  logic [QW-1:0] dqim  [QW+1];
  logic [MW-1:0] dn    [QW+1];
  logic          nre   [QW+1];
  logic          nim   [QW+1];
  logic [W-1:0]  fre   [QW+1];
  logic [W-1:0]  fim   [QW+1];
  ctl_t          cc    [QW+1];

  assign v[0]    = in_valid;
  assign rre[0]  = '0;
  assign rim[0]  = '0;
  assign dqre[0] = {num_re_mag, {FRAC_BITS{1'b0}}};
  assign dqim[0] = {num_im_mag, {FRAC_BITS{1'b0}}};
  assign dn[0]   = den;
  assign nre[0]  = num_re_neg;
  assign nim[0]  = num_im_neg;
  assign fre[0]  = fast_re_in;
  assign fim[0]  = fast_im_in;
  assign cc[0]   = ctl_in;

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [MW:0] tre, tim;
    logic        gre, gim;

    always_comb begin
      tre = {rre[k-1], dqre[k-1][QW-1]};
      tim = {rim[k-1], dqim[k-1][QW-1]};
      gre = tre >= {1'b0, dn[k-1]};
      gim = tim >= {1'b0, dn[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        rre[k]  <= gre ? MW'(tre - {1'b0, dn[k-1]}) : tre[MW-1:0];
        rim[k]  <= gim ? MW'(tim - {1'b0, dn[k-1]}) : tim[MW-1:0];
        dqre[k] <= {dqre[k-1][QW-2:0], gre};
        dqim[k] <= {dqim[k-1][QW-2:0], gim};
        dn[k]   <= dn[k-1];
        nre[k]  <= nre[k-1];
        nim[k]  <= nim[k-1];
        fre[k]  <= fre[k-1];
        fim[k]  <= fim[k-1];
        cc[k]   <= cc[k-1];
      end
    end
  end

  assign out_valid = v[QW];
  assign q_re      = dqre[QW];
  assign q_im      = dqim[QW];
  assign q_re_neg  = nre[QW];
  assign q_im_neg  = nim[QW];
  assign fast_re   = fre[QW];
  assign fast_im   = fim[QW];
  assign ctl       = cc[QW];
endmodule
